// ----- rtl/tfc_pkg.sv -----
package tfc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE        = 3'd0;
    localparam logic [2:0] CFG_FIELD_INDEX = 3'd1;
    localparam logic [2:0] CFG_DELIMITERS  = 3'd2;
    localparam logic [2:0] CFG_PATTERN     = 3'd3;
    localparam logic [2:0] CFG_FOLD_CASE   = 3'd4;
    localparam logic [2:0] CFG_SKIP_OFFSET = 3'd5;
    localparam logic [2:0] CFG_TAKE_LENGTH = 3'd6;

    // operating modes (code 3 behaves as whole line)
    localparam logic [1:0] MODE_LINE  = 2'd0;
    localparam logic [1:0] MODE_FIELD = 2'd1;
    localparam logic [1:0] MODE_RAW   = 2'd2;

    // register widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int FIELD_W    = 16;
    localparam int LINE_POS_W = 32;
    localparam int RAW_POS_W  = 64;

    // defaults for the top level parameters
    localparam int MATCH_MAX_DEF = 8;
    localparam int DELIM_MAX_DEF = 4;

    localparam logic [31:0] DELIM_RESET = 32'd44;
    localparam logic [7:0]  LINE_FEED   = 8'd10;

    // control from the top level to the select unit
    typedef struct packed {
        logic en;
        logic clr;
        logic field_mode;
        logic delim;
    } t_sel_ctrl;

    // ascii upper-case fold when enabled
    function automatic logic [7:0] f_fold(input logic [7:0] b, input logic en);
        logic [7:0] r;
        r = b;
        if (en && b >= 8'd97 && b <= 8'd122) begin
            r = b - 8'd32;
        end
        return r;
    endfunction

endpackage

// ----- rtl/text_field_cut_filter_unit.sv -----
// an accepted request passes from the input register to the output register
// throughput: one request per cycle while the output is free; a pattern match
//   replays the matched bytes through the field and range unit, one per cycle
//   while the output is free, and the input register holds the next request
// reset: synchronous, active low; clears line and stream state and loads
//   register defaults (comma delimiter, matching off, no range limit)
module text_field_cut_filter_unit
    import tfc_pkg::*;
#(
    parameter int MATCH_MAX = MATCH_MAX_DEF,
    parameter int DELIM_MAX = DELIM_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte
    input  logic [0:0]            s_tuser,   // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // out_byte
    output logic                  m_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LEN_W = $clog2(MATCH_MAX + 1);
    localparam int IDX_W = (MATCH_MAX > 1) ? $clog2(MATCH_MAX) : 1;

    // configuration registers
    logic [1:0]            r_mode;
    logic [FIELD_W-1:0]    r_field_idx;
    logic [31:0]           r_delim;
    logic [63:0]           r_pat;
    logic                  r_fold;
    logic [RAW_POS_W-1:0]  r_off;
    logic [RAW_POS_W-1:0]  r_len;

    // input register
    logic       r_in_vld, n_in_vld;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    // match window and replay buffer
    logic [7:0]       r_win [MATCH_MAX];
    logic [7:0]       n_win [MATCH_MAX];
    logic [LEN_W-1:0] r_seen, n_seen;
    logic             r_match, n_match;
    logic             r_burst_act, n_burst_act;
    logic [LEN_W-1:0] r_burst_idx, n_burst_idx;
    logic [LEN_W-1:0] r_burst_len, n_burst_len;
    logic [7:0]       r_buf [MATCH_MAX];
    logic [7:0]       n_buf [MATCH_MAX];
    logic             r_hold_vld, n_hold_vld;
    logic [7:0]       r_hold_byte, n_hold_byte;

    // output register and raw position
    logic                 r_out_vld, n_out_vld;
    logic [7:0]           r_out_byte, n_out_byte;
    logic                 r_out_last, n_out_last;
    logic [RAW_POS_W-1:0] r_spos, n_spos;
    logic [RAW_POS_W-1:0] spos_rel;

    logic             out_free, item_go, burst_go, burst_sel, burst_end;
    logic             is_raw, line_data, line_eol, direct, scan, raw_put;
    logic [LEN_W-1:0] plen;
    logic             plen_live;
    logic             delim_hit, delim_live;
    logic [7:0]       sel_byte;
    logic [7:0]       win_new [MATCH_MAX];
    logic [LEN_W-1:0] seen_new;
    logic             hit;
    logic             sel_put, emitted;
    t_sel_ctrl        sel_ctrl;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LINE;
            r_field_idx <= '0;
            r_delim     <= DELIM_RESET;
            r_pat       <= '0;
            r_fold      <= 1'b0;
            r_off       <= '0;
            r_len       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:        r_mode      <= i_cfg_data[1:0];
                CFG_FIELD_INDEX: r_field_idx <= i_cfg_data[FIELD_W-1:0];
                CFG_DELIMITERS:  r_delim     <= i_cfg_data[31:0];
                CFG_PATTERN:     r_pat       <= i_cfg_data;
                CFG_FOLD_CASE:   r_fold      <= i_cfg_data[0];
                CFG_SKIP_OFFSET: r_off       <= i_cfg_data;
                CFG_TAKE_LENGTH: r_len       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake and step selection
    assign out_free  = !r_out_vld || m_tready;
    assign item_go   = r_in_vld && !r_burst_act && out_free;
    assign burst_go  = r_burst_act && out_free;
    assign burst_sel = burst_go && (r_burst_idx != r_burst_len);
    assign burst_end = burst_go && (r_burst_idx == r_burst_len);
    assign is_raw    = (r_mode == MODE_RAW);
    assign line_data = item_go && !is_raw && !r_in_op;
    assign line_eol  = item_go && !is_raw && r_in_op;
    assign direct    = line_data && (plen == '0 || r_match);
    assign scan      = line_data && plen != '0 && !r_match;
    assign s_tready  = !r_in_vld || item_go;

    // pattern length: bytes up to the first zero
    always_comb begin
        plen      = '0;
        plen_live = 1'b1;
        for (int i = 0; i < MATCH_MAX; i++) begin
            if (plen_live && r_pat[8*i +: 8] != 8'd0) begin
                plen = LEN_W'(i + 1);
            end else begin
                plen_live = 1'b0;
            end
        end
    end

    // byte fed to the select unit
    assign sel_byte = burst_sel ? r_buf[r_burst_idx[IDX_W-1:0]] : r_in_byte;

    // delimiter test, list ends at a zero byte
    always_comb begin
        delim_hit  = 1'b0;
        delim_live = 1'b1;
        for (int i = 0; i < DELIM_MAX; i++) begin
            if (r_delim[8*i +: 8] == 8'd0) begin
                delim_live = 1'b0;
            end else if (delim_live && r_delim[8*i +: 8] == sel_byte) begin
                delim_hit = 1'b1;
            end
        end
    end

    assign sel_ctrl.en         = burst_sel || direct;
    assign sel_ctrl.clr        = line_eol;
    assign sel_ctrl.field_mode = (r_mode == MODE_FIELD);
    assign sel_ctrl.delim      = delim_hit;

    tfc_select u_select (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (sel_ctrl),
        .i_field_index (r_field_idx),
        .i_off         (r_off[LINE_POS_W-1:0]),
        .i_len         (r_len[LINE_POS_W-1:0]),
        .o_put         (sel_put),
        .o_emitted     (emitted)
    );

    // shifted window and pattern compare
    always_comb begin
        for (int i = 0; i < MATCH_MAX - 1; i++) begin
            win_new[i] = r_win[i + 1];
        end
        win_new[MATCH_MAX-1] = r_in_byte;
        seen_new = (r_seen != LEN_W'(MATCH_MAX)) ? r_seen + 1'b1 : r_seen;
        hit      = (seen_new >= plen);
        for (int i = 0; i < MATCH_MAX; i++) begin
            if (i < int'(plen)) begin
                if (f_fold(win_new[IDX_W'(MATCH_MAX - int'(plen) + i)], r_fold) !=
                    f_fold(r_pat[8*i +: 8], r_fold)) begin
                    hit = 1'b0;
                end
            end
        end
    end

    // raw stream range
    assign spos_rel = r_spos - r_off;
    assign raw_put  = item_go && is_raw && !r_in_op && r_spos >= r_off &&
                      (r_len == '0 || spos_rel < r_len);

    // next state of window, replay and output
    always_comb begin
        n_win       = r_win;
        n_seen      = r_seen;
        n_match     = r_match;
        n_buf       = r_buf;
        n_burst_act = r_burst_act;
        n_burst_idx = r_burst_idx;
        n_burst_len = r_burst_len;
        n_hold_vld  = r_hold_vld;
        n_hold_byte = r_hold_byte;
        n_out_vld   = r_out_vld && !m_tready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_spos      = r_spos;

        // window scan until the pattern is found
        if (scan) begin
            n_win  = win_new;
            n_seen = seen_new;
            if (hit) begin
                n_match     = 1'b1;
                n_burst_act = 1'b1;
                n_burst_idx = '0;
                n_burst_len = plen;
                for (int i = 0; i < MATCH_MAX; i++) begin
                    if (i < int'(plen)) begin
                        n_buf[i] = win_new[IDX_W'(MATCH_MAX - int'(plen) + i)];
                    end
                end
            end
        end

        // end of line clears line state
        if (line_eol) begin
            n_seen  = '0;
            n_match = 1'b0;
            if (emitted) begin
                n_out_vld  = 1'b1;
                n_out_byte = LINE_FEED;
                n_out_last = 1'b1;
            end
        end

        // replay: a byte is held until the next one shows whether it is last
        if (burst_sel) begin
            n_burst_idx = r_burst_idx + 1'b1;
            if (sel_put) begin
                if (r_hold_vld) begin
                    n_out_vld  = 1'b1;
                    n_out_byte = r_hold_byte;
                    n_out_last = 1'b0;
                end
                n_hold_vld  = 1'b1;
                n_hold_byte = sel_byte;
            end
        end

        if (burst_end) begin
            n_burst_act = 1'b0;
            n_hold_vld  = 1'b0;
            if (r_hold_vld) begin
                n_out_vld  = 1'b1;
                n_out_byte = r_hold_byte;
                n_out_last = 1'b1;
            end
        end

        // single byte through the select unit
        if (direct && sel_put) begin
            n_out_vld  = 1'b1;
            n_out_byte = r_in_byte;
            n_out_last = 1'b1;
        end

        // raw stream position
        if (item_go && is_raw) begin
            if (r_in_op) begin
                n_spos = '0;
            end else if (r_spos != '1) begin
                n_spos = r_spos + 1'b1;
            end
        end

        if (raw_put) begin
            n_out_vld  = 1'b1;
            n_out_byte = r_in_byte;
            n_out_last = 1'b1;
        end
    end

    // input register
    always_comb begin
        n_in_vld = r_in_vld;
        if (s_tvalid && s_tready) begin
            n_in_vld = 1'b1;
        end else if (item_go) begin
            n_in_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_op   <= s_tuser[0];
            r_in_byte <= s_tdata;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_win       <= n_win;
        r_buf       <= n_buf;
        r_burst_idx <= n_burst_idx;
        r_burst_len <= n_burst_len;
        r_hold_byte <= n_hold_byte;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_seen      <= '0;
            r_match     <= 1'b0;
            r_burst_act <= 1'b0;
            r_hold_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
            r_spos      <= '0;
        end else begin
            r_in_vld    <= n_in_vld;
            r_seen      <= n_seen;
            r_match     <= n_match;
            r_burst_act <= n_burst_act;
            r_hold_vld  <= n_hold_vld;
            r_out_vld   <= n_out_vld;
            r_spos      <= n_spos;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out_byte;
    assign m_tlast  = r_out_last;

    // a held replay byte only exists inside a replay
    a_hold_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_vld |-> r_burst_act)
        else $error("held byte outside of a replay");

    // replay index never runs past the pattern length
    a_burst_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst_act |-> (r_burst_idx <= r_burst_len && r_burst_len != '0))
        else $error("replay index out of range");

    // a replay only follows a pattern match
    a_burst_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst_act |-> r_match)
        else $error("replay without match");

    // the closing replay step drains the held byte and ends the replay
    a_burst_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        burst_end |=> (!r_burst_act && !r_hold_vld))
        else $error("replay did not close");

endmodule

// ----- rtl/tfc_select.sv -----
module tfc_select
    import tfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_sel_ctrl             i_ctrl,
    input  logic [FIELD_W-1:0]    i_field_index,
    input  logic [LINE_POS_W-1:0] i_off,
    input  logic [LINE_POS_W-1:0] i_len,
    output logic                  o_put,
    output logic                  o_emitted
);

    logic [FIELD_W-1:0]    r_cur_field, n_cur_field;
    logic                  r_closed, n_closed;
    logic [LINE_POS_W-1:0] r_pos, n_pos;
    logic                  r_emitted, n_emitted;
    logic                  take;
    logic [LINE_POS_W-1:0] rel;

    assign rel = r_pos - i_off;

    // field tracking and byte range check for one line byte
    always_comb begin
        o_put       = 1'b0;
        take        = 1'b0;
        n_cur_field = r_cur_field;
        n_closed    = r_closed;
        n_pos       = r_pos;
        n_emitted   = r_emitted;
        if (i_ctrl.clr) begin
            n_cur_field = '0;
            n_closed    = 1'b0;
            n_pos       = '0;
            n_emitted   = 1'b0;
        end else if (i_ctrl.en) begin
            take = 1'b1;
            if (i_ctrl.field_mode) begin
                if (r_cur_field < i_field_index) begin
                    take = 1'b0;
                    if (i_ctrl.delim) begin
                        n_cur_field = r_cur_field + 1'b1;
                    end
                end else if (r_closed) begin
                    take = 1'b0;
                end else if (i_ctrl.delim) begin
                    take     = 1'b0;
                    n_closed = 1'b1;
                end
            end
            if (take) begin
                if (r_pos != '1) begin
                    n_pos = r_pos + 1'b1;
                end
                if (r_pos >= i_off && (i_len == '0 || rel < i_len)) begin
                    o_put     = 1'b1;
                    n_emitted = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_field <= '0;
            r_closed    <= 1'b0;
            r_pos       <= '0;
            r_emitted   <= 1'b0;
        end else begin
            r_cur_field <= n_cur_field;
            r_closed    <= n_closed;
            r_pos       <= n_pos;
            r_emitted   <= n_emitted;
        end
    end

    assign o_emitted = r_emitted;

endmodule

// ----- tb/sv/tfc_cut_checker.sv -----
`timescale 1ns / 1ps

module tfc_cut_checker
    import tfc_pkg::*;
#(
    parameter int MATCH_MAX = MATCH_MAX_DEF,
    parameter int DELIM_MAX = DELIM_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // data_byte
    input  logic [0:0]            s_tuser,   // op
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,   // out_byte
    input  logic                  m_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_cut_result;

    // shadow of the configuration registers
    logic [1:0]  mode_q;
    logic [15:0] field_sel;
    logic [31:0] delim_set;
    logic [63:0] pattern;
    logic        fold_on;
    logic [63:0] skip_cnt;
    logic [63:0] take_cnt;

    // line and stream state
    logic [7:0]  window [MATCH_MAX];
    logic [3:0]  seen_cnt;
    logic        matched;
    logic [15:0] field_no;
    logic        field_done;
    logic [31:0] field_pos;
    logic        line_emitted;
    logic [63:0] raw_pos;

    logic [7:0]  cut_bytes [$];
    t_cut_result expected_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [7:0] fold_letter(input logic [7:0] b);
        return (fold_on && b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
    endfunction

    // delimiter list ends at the first zero byte
    function automatic logic is_delimiter(input logic [7:0] b);
        logic [7:0] d;
        for (int i = 0; i < DELIM_MAX; i++) begin
            d = delim_set[8*i +: 8];
            if (d == 8'h00) return 1'b0;
            if (d == b) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int pattern_length();
        int n;
        n = 0;
        while (n < MATCH_MAX && pattern[8*n +: 8] != 8'h00) n++;
        return n;
    endfunction

    task automatic clear_line_state();
        for (int i = 0; i < MATCH_MAX; i++) window[i] = 8'h00;
        seen_cnt     = '0;
        matched      = 1'b0;
        field_no     = '0;
        field_done   = 1'b0;
        field_pos    = '0;
        line_emitted = 1'b0;
    endtask

    // field selection and offset/length window for one line byte
    task automatic keep_byte(input logic [7:0] b);
        logic [31:0] pos;
        if (mode_q == MODE_FIELD) begin
            if (field_no < field_sel) begin
                if (is_delimiter(b)) field_no++;
                return;
            end
            if (field_done) return;
            if (is_delimiter(b)) begin
                field_done = 1'b1;
                return;
            end
        end
        pos = field_pos;
        if (field_pos != '1) field_pos++;
        if (pos >= skip_cnt[31:0] &&
            (take_cnt[31:0] == 32'd0 || pos - skip_cnt[31:0] < take_cnt[31:0])) begin
            cut_bytes.push_back(b);
            line_emitted = 1'b1;
        end
    endtask

    // expected output bytes for one accepted request
    task automatic cut_request(input logic op, input logic [7:0] b);
        int   plen;
        int   n;
        logic hit;
        cut_bytes.delete();
        if (mode_q == MODE_RAW) begin
            if (op) begin
                raw_pos = '0;
            end else begin
                if (raw_pos >= skip_cnt &&
                    (take_cnt == 64'd0 || raw_pos - skip_cnt < take_cnt)) begin
                    cut_bytes.push_back(b);
                end
                if (raw_pos != '1) raw_pos++;
            end
        end else if (op) begin
            if (line_emitted) cut_bytes.push_back(LINE_FEED);
            clear_line_state();
        end else begin
            plen = pattern_length();
            if (plen == 0 || matched) begin
                keep_byte(b);
            end else begin
                // slide the window and look for the pattern at its tail
                for (int i = 0; i < MATCH_MAX - 1; i++) window[i] = window[i+1];
                window[MATCH_MAX-1] = b;
                if (seen_cnt < MATCH_MAX) seen_cnt++;
                hit = (int'(seen_cnt) >= plen);
                for (int i = 0; hit && i < plen; i++) begin
                    if (fold_letter(window[MATCH_MAX-plen+i]) != fold_letter(pattern[8*i +: 8]))
                        hit = 1'b0;
                end
                // replay the matched bytes
                if (hit) begin
                    matched = 1'b1;
                    for (int i = 0; i < plen; i++) keep_byte(window[MATCH_MAX-plen+i]);
                end
            end
        end
        n = cut_bytes.size();
        for (int i = 0; i < n; i++) begin
            expected_q.push_back('{out_byte: cut_bytes[i], last_of_run: (i == n - 1)});
        end
    endtask

    task automatic check_result();
        t_cut_result exp_res;
        if (expected_q.size() == 0) begin
            $error("unexpected result: out_byte 8'h%02h last_of_run %0b", m_tdata, m_tlast);
            o_fail_count++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (m_tdata !== exp_res.out_byte) begin
            $error("out_byte: expected 8'h%02h, got 8'h%02h", exp_res.out_byte, m_tdata);
            o_fail_count++;
        end
        if (m_tlast !== exp_res.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", exp_res.last_of_run, m_tlast);
            o_fail_count++;
        end
    endtask

    // results first, then register writes, then the new request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q    = MODE_LINE;
            field_sel = '0;
            delim_set = DELIM_RESET;
            pattern   = '0;
            fold_on   = 1'b0;
            skip_cnt  = '0;
            take_cnt  = '0;
            raw_pos   = '0;
            clear_line_state();
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:        mode_q    = i_cfg_data[1:0];
                    CFG_FIELD_INDEX: field_sel = i_cfg_data[15:0];
                    CFG_DELIMITERS:  delim_set = i_cfg_data[31:0];
                    CFG_PATTERN:     pattern   = i_cfg_data;
                    CFG_FOLD_CASE:   fold_on   = i_cfg_data[0];
                    CFG_SKIP_OFFSET: skip_cnt  = i_cfg_data;
                    CFG_TAKE_LENGTH: take_cnt  = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) cut_request(s_tuser[0], s_tdata);
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- tb/sv/tb_text_field_cut_filter_unit.sv -----
`timescale 1ns / 1ps

module tb_text_field_cut_filter_unit;
    import tfc_pkg::*;

    localparam int         RANDOM_REQS    = 420;
    localparam int         RX_HOLD_CYCLES = 60;
    localparam int         DRAIN_CYCLES   = MATCH_MAX_DEF + 6;
    localparam int         STALL_LIMIT    = 1000;
    localparam logic [1:0] MODE_LINE_ALT  = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int sent_cnt;
    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold_req;

    // stimulus shaping from the current setup
    logic [7:0] pat_q [$];
    logic [7:0] delim_q [$];
    logic       fold_now;
    logic [8:0] line_q [$];

    text_field_cut_filter_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tfc_cut_checker u_cut_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stop when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_text_field_cut_filter_unit NOT OK");
        $finish;
    end

    // result side: random ready gaps, one long hold-off on demand
    initial begin : result_sink
        int wait_cycles;
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                wait_cycles = RX_HOLD_CYCLES;
            end else begin
                wait_cycles = rx_idle_on ? $urandom_range(0, 12) : 0;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_tvalid && i_rst_n));
        end
    end

    // one request, starting and ending at a falling edge
    task automatic send_req(input logic op, input logic [7:0] data);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    // hold requests until every expected result is out and the pipe is empty
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_setup(input logic [1:0] md, input logic [15:0] fidx,
                               input logic [31:0] delims, input logic [63:0] pat,
                               input logic fc, input logic [63:0] skip,
                               input logic [63:0] take);
        drain_block();
        write_reg(CFG_MODE, 64'(md));
        write_reg(CFG_FIELD_INDEX, 64'(fidx));
        write_reg(CFG_DELIMITERS, 64'(delims));
        write_reg(CFG_PATTERN, pat);
        write_reg(CFG_FOLD_CASE, 64'(fc));
        write_reg(CFG_SKIP_OFFSET, skip);
        write_reg(CFG_TAKE_LENGTH, take);
        // byte lists used to shape the text
        pat_q.delete();
        for (int i = 0; i < MATCH_MAX_DEF && pat[8*i +: 8] != 8'h00; i++)
            pat_q.push_back(pat[8*i +: 8]);
        delim_q.delete();
        for (int i = 0; i < DELIM_MAX_DEF && delims[8*i +: 8] != 8'h00; i++)
            delim_q.push_back(delims[8*i +: 8]);
        fold_now = fc;
    endtask

    function automatic logic [7:0] pick_letter();
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 5));
    endfunction

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return pick_letter();
            3, 4:    return (delim_q.size() > 0) ?
                            delim_q[$urandom_range(0, delim_q.size() - 1)] : 8'h2C;
            5:       return 8'h00;
            6:       return 8'($urandom);
            7:       return (pat_q.size() > 0) ?
                            pat_q[$urandom_range(0, pat_q.size() - 1)] : 8'h78;
            default: return 8'h30 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    // random setup, weighted toward small ranges and short patterns
    task automatic random_setup();
        logic [1:0]  md;
        logic [15:0] fidx;
        logic [31:0] delims;
        logic [63:0] pat;
        logic [63:0] skip;
        logic [63:0] take;
        int          n;
        md = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0:       fidx = 16'd0;
            1:       fidx = 16'd1;
            2:       fidx = 16'd2;
            3:       fidx = 16'hFFFF;
            default: fidx = 16'($urandom_range(0, 3));
        endcase
        case ($urandom_range(0, 5))
            0:       delims = 32'h0;
            1:       delims = DELIM_RESET;
            2:       delims = 32'h0000_3B2C;
            3:       delims = 32'h7C3B_2C20;
            4:       delims = 32'h2C00_003B;
            default: delims = $urandom;
        endcase
        n = ($urandom_range(0, 5) == 0) ? MATCH_MAX_DEF : $urandom_range(0, 3);
        pat = '0;
        for (int i = 0; i < n; i++)
            pat[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'h2C : pick_letter();
        // occasionally a raw pattern, possibly cut short by a zero byte
        if ($urandom_range(0, 7) == 0) pat = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       skip = '1;
            1:       skip = {32'd1, 32'd1};
            2:       skip = {$urandom, $urandom};
            default: skip = 64'($urandom_range(0, 4));
        endcase
        case ($urandom_range(0, 7))
            0:       take = '1;
            1:       take = {32'd1, 32'd0};
            2:       take = {$urandom, $urandom};
            3:       take = '0;
            default: take = 64'($urandom_range(1, 5));
        endcase
        apply_setup(md, fidx, delims, pat, 1'($urandom_range(0, 1)), skip, take);
    endtask

    // a line of text, often holding the pattern, sometimes a broken one
    task automatic build_line();
        int         len;
        int         ins_at;
        int         plen;
        logic [7:0] b;
        line_q.delete();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 8);
        for (int i = 0; i < len; i++) line_q.push_back({1'b0, pick_text_byte()});
        if (pat_q.size() > 0 && $urandom_range(0, 3) != 0) begin
            plen = pat_q.size();
            if ($urandom_range(0, 4) == 0) plen--;
            ins_at = $urandom_range(0, len);
            for (int i = plen - 1; i >= 0; i--) begin
                b = pat_q[i];
                if (fold_now && (b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A &&
                    $urandom_range(0, 1))
                    b = b ^ 8'h20;
                line_q.insert(ins_at, {1'b0, b});
            end
        end
        line_q.push_back({1'b1, 8'($urandom)});
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int         goal;
        int         phase_end;
        logic [8:0] req_item;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_MODE;
        i_cfg_data  = '0;
        sent_cnt    = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold_req = 1'b0;
        fold_now    = 1'b0;
        delim_q.push_back(8'h2C);
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: whole line, then an empty line
        send_req(1'b0, "a");
        send_req(1'b0, "b");
        send_req(1'b1, 8'h00);
        send_req(1'b1, 8'hFF);

        // mode three with a case-folded pattern
        apply_setup(MODE_LINE_ALT, 16'd0, DELIM_RESET, 64'h6463, 1'b1, 64'd0, 64'd0);
        send_req(1'b0, "x");
        send_req(1'b0, "C");
        send_req(1'b0, "D");
        send_req(1'b0, "z");
        send_req(1'b1, 8'h00);

        // empty delimiter list: field one is missing
        apply_setup(MODE_FIELD, 16'd1, 32'h0, 64'd0, 1'b0, 64'd0, 64'd0);
        send_req(1'b0, "a");
        send_req(1'b0, ",");
        send_req(1'b0, "b");
        send_req(1'b1, 8'h00);

        // zero data byte is not a delimiter
        apply_setup(MODE_FIELD, 16'd1, DELIM_RESET, 64'd0, 1'b0, 64'd0, 64'd0);
        send_req(1'b0, "a");
        send_req(1'b0, 8'h00);
        send_req(1'b0, ",");
        send_req(1'b0, "b");
        send_req(1'b1, 8'h00);

        // raw byte range and end of stream
        apply_setup(MODE_RAW, 16'd0, DELIM_RESET, 64'd0, 1'b0, 64'd1, 64'd2);
        send_req(1'b0, 8'hFF);
        send_req(1'b0, 8'h00);
        send_req(1'b0, 8'h80);
        send_req(1'b0, 8'h7F);
        send_req(1'b1, 8'h55);

        // random phases; a phase may end mid-line
        goal = sent_cnt + RANDOM_REQS;
        for (int phase = 0; sent_cnt < goal; phase++) begin
            if (phase == 2) begin
                // long receiver hold-off while requests keep coming
                apply_setup(MODE_LINE, 16'd0, DELIM_RESET, 64'd0, 1'b0, 64'd0, 64'd0);
                tx_idle_on  = 1'b0;
                rx_idle_on  = 1'b0;
                rx_hold_req = 1'b1;
                phase_end   = sent_cnt + 40;
            end else begin
                random_setup();
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
                phase_end  = sent_cnt + $urandom_range(20, 40);
            end
            while (sent_cnt < phase_end) begin
                build_line();
                while (line_q.size() > 0 && sent_cnt < phase_end) begin
                    req_item = line_q.pop_front();
                    send_req(req_item[8], req_item[7:0]);
                end
            end
        end

        drain_block();
        if (fail_count == 0 && pending == 0)
            $display("tb_text_field_cut_filter_unit OK");
        else
            $display("tb_text_field_cut_filter_unit NOT OK");
        $finish;
    end

endmodule
